// File: rtl/core/adp_pkg.sv
// ---------------------------------------------------------------------------
// Archive directory parser package
// Shared widths, result codes, error codes and the result record type.
// ---------------------------------------------------------------------------
package adp_pkg;

	// Field widths.
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned OFF_W   = 31;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned ERR_W   = 3;
	localparam int unsigned TDATA_W = 80;

	// Directory layout constants.
	localparam logic [OFF_W-1:0] MIN_FILE   = OFF_W'(5);
	localparam logic [OFF_W-1:0] WORD_BYTES = OFF_W'(4);

	// Result kinds.
	localparam logic [KIND_W-1:0] KIND_NAME    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ENTRY   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_VALID   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_INVALID = 2'd3;

	// Error codes.
	localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
	localparam logic [ERR_W-1:0] ERR_SHORT     = 3'd1;
	localparam logic [ERR_W-1:0] ERR_FIRST_OFF = 3'd2;
	localparam logic [ERR_W-1:0] ERR_ORDER     = 3'd3;
	localparam logic [ERR_W-1:0] ERR_END       = 3'd4;
	localparam logic [ERR_W-1:0] ERR_PAST_END  = 3'd5;

	// One result record.
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [BYTE_W-1:0] name_char;
		logic [OFF_W-1:0]  entry_offset;
		logic [OFF_W-1:0]  entry_size;
		logic [ERR_W-1:0]  error_code;
		logic              last;
	} result_t;

	// ASCII uppercase letters map to lowercase; all other bytes pass.
	function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		r = b;
		if (b >= 8'h41 && b <= 8'h5A) begin
			r = b + 8'h20;
		end
		return r;
	endfunction

endpackage

// File: rtl/core/archive_directory_parser_top.sv
// ---------------------------------------------------------------------------
// Archive directory parser
// Checks the directory at the head of an archive byte stream and reports
// lowercased name bytes, entry records and one final verdict.
// ---------------------------------------------------------------------------
// The block takes one archive byte per cycle on the slave stream and keeps
// that rate without a gap unless back pressure holds it: every byte passes
// an input register, one stage of compare and subtract logic that updates
// the parser state and, if it makes a result, an output register; the next
// byte may enter in the very next cycle. The single state-update stage sets
// that one-byte-per-cycle figure. Back pressure on the master stream stalls
// the input only while a byte that produces a result waits for the output
// register. Assert tuser with the byte at file position zero to restart the
// parser; file_size must be written while the block is idle. After the
// verdict (tlast high) later bytes give no result until the next restart.
module archive_directory_parser_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration: file_size.
	input  logic                            cfg_wr_en,
	input  logic [adp_pkg::OFF_W-1:0]       cfg_wr_data,
	// Input stream.
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [adp_pkg::BYTE_W-1:0]      s_axis_tdata,   // data_byte
	input  logic                            s_axis_tuser,   // first_byte
	// Output stream.
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// name_char[7:0], entry_offset[38:8], entry_size[69:39],
	// error_code[72:70], zero fill[79:73]
	output logic [adp_pkg::TDATA_W-1:0]     m_axis_tdata,
	output logic [adp_pkg::KIND_W-1:0]      m_axis_tuser,   // result_kind
	output logic                            m_axis_tlast    // last
);

	localparam logic [1:0] PH_OFFSET = 2'd0;
	localparam logic [1:0] PH_NAME   = 2'd1;
	localparam logic [1:0] PH_DONE   = 2'd2;

	localparam int unsigned OW = adp_pkg::OFF_W;
	localparam int unsigned WW = adp_pkg::WORD_W;

	// Configuration register.
	logic [OW-1:0] file_size_q;

	// Input stage.
	logic                        valid_s1;
	logic [adp_pkg::BYTE_W-1:0]  data_s1;
	logic                        first_s1;

	// Parser state.
	logic [1:0]    phase_q;
	logic [1:0]    biw_q;
	logic [WW-1:0] acc_q;
	logic [OW-1:0] first_off_q;
	logic [OW-1:0] prev_off_q;
	logic [OW-1:0] pos_q;

	// Output stage.
	logic              valid_s2;
	adp_pkg::result_t  res_s2;

	// Effective state after an optional restart, and next state.
	logic [1:0]    ph_e, biw_e;
	logic [WW-1:0] acc_e;
	logic [OW-1:0] first_e, prev_e, pos_e;
	logic [1:0]    ph_n, biw_n;
	logic [WW-1:0] acc_n, acc_word;
	logic [OW-1:0] first_n, prev_n, pos_n, pos_inc;
	logic [OW-1:0] sub_a;
	logic [OW-1:0] diff;
	logic          emit;
	adp_pkg::result_t res;

	logic out_free;
	logic adv_s1;

	// Handshake control.
	assign out_free      = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && (!emit || out_free);
	assign s_axis_tready = !valid_s1 || adv_s1;

	// Configuration write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_size_q <= '0;
		end else if (cfg_wr_en) begin
			file_size_q <= cfg_wr_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1  <= s_axis_tdata;
			first_s1 <= s_axis_tuser;
		end
	end

	// Parse step: checks, accumulation and the result record.
	always_comb begin
		if (first_s1) begin
			ph_e    = PH_OFFSET;
			biw_e   = '0;
			acc_e   = '0;
			first_e = '0;
			prev_e  = '0;
			pos_e   = '0;
		end else begin
			ph_e    = phase_q;
			biw_e   = biw_q;
			acc_e   = acc_q;
			first_e = first_off_q;
			prev_e  = prev_off_q;
			pos_e   = pos_q;
		end

		pos_inc  = pos_e + OW'(1);
		acc_word = acc_e | (WW'(data_s1) << {biw_e, 3'b000});

		// One subtractor serves both entry sizes.
		sub_a = (acc_word == '0) ? file_size_q : acc_word[OW-1:0];
		diff  = sub_a - prev_e;

		ph_n    = ph_e;
		biw_n   = biw_e;
		acc_n   = acc_e;
		first_n = first_e;
		prev_n  = prev_e;
		pos_n   = pos_inc;
		emit    = 1'b0;
		res     = '0;

		if (ph_e == PH_DONE) begin
			pos_n = pos_e;
		end else if (pos_e == '0 && file_size_q < adp_pkg::MIN_FILE) begin
			emit           = 1'b1;
			ph_n           = PH_DONE;
			res.kind       = adp_pkg::KIND_INVALID;
			res.error_code = adp_pkg::ERR_SHORT;
			res.last       = 1'b1;
		end else if (ph_e == PH_OFFSET && biw_e == '0 && pos_e >= adp_pkg::WORD_BYTES
				&& pos_e >= first_e) begin
			emit           = 1'b1;
			ph_n           = PH_DONE;
			res.kind       = adp_pkg::KIND_INVALID;
			res.error_code = adp_pkg::ERR_END;
			res.last       = 1'b1;
		end else if (pos_e >= file_size_q) begin
			emit           = 1'b1;
			ph_n           = PH_DONE;
			res.kind       = adp_pkg::KIND_INVALID;
			res.error_code = adp_pkg::ERR_PAST_END;
			res.last       = 1'b1;
		end else if (ph_e == PH_NAME) begin
			if (data_s1 == '0) begin
				ph_n  = PH_OFFSET;
				biw_n = '0;
				acc_n = '0;
			end else begin
				emit          = 1'b1;
				res.kind      = adp_pkg::KIND_NAME;
				res.name_char = adp_pkg::to_lower(data_s1);
			end
		end else if (biw_e != 2'd3) begin
			// Still collecting offset bytes.
			acc_n = acc_word;
			biw_n = biw_e + 2'd1;
		end else begin
			acc_n = acc_word;
			biw_n = '0;
			if (pos_e < adp_pkg::WORD_BYTES) begin
				// First offset bounds the directory area.
				if (acc_word[WW-1] || acc_word < WW'(adp_pkg::MIN_FILE)
						|| acc_word[OW-1:0] > file_size_q) begin
					emit           = 1'b1;
					ph_n           = PH_DONE;
					res.kind       = adp_pkg::KIND_INVALID;
					res.error_code = adp_pkg::ERR_FIRST_OFF;
					res.last       = 1'b1;
				end else begin
					first_n = acc_word[OW-1:0];
					prev_n  = acc_word[OW-1:0];
					ph_n    = PH_NAME;
				end
			end else if (acc_word == '0) begin
				// End marker must finish exactly at the first offset.
				emit     = 1'b1;
				ph_n     = PH_DONE;
				res.last = 1'b1;
				if (pos_inc != first_e) begin
					res.kind       = adp_pkg::KIND_INVALID;
					res.error_code = adp_pkg::ERR_END;
				end else begin
					res.kind         = adp_pkg::KIND_VALID;
					res.entry_offset = prev_e;
					res.entry_size   = diff;
				end
			end else if (acc_word[WW-1] || acc_word[OW-1:0] < prev_e
					|| acc_word[OW-1:0] > file_size_q) begin
				emit           = 1'b1;
				ph_n           = PH_DONE;
				res.kind       = adp_pkg::KIND_INVALID;
				res.error_code = adp_pkg::ERR_ORDER;
				res.last       = 1'b1;
			end else begin
				emit             = 1'b1;
				prev_n           = acc_word[OW-1:0];
				ph_n             = PH_NAME;
				res.kind         = adp_pkg::KIND_ENTRY;
				res.entry_offset = prev_e;
				res.entry_size   = diff;
			end
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_OFFSET;
			biw_q       <= '0;
			acc_q       <= '0;
			first_off_q <= '0;
			prev_off_q  <= '0;
			pos_q       <= '0;
		end else if (adv_s1) begin
			phase_q     <= ph_n;
			biw_q       <= biw_n;
			acc_q       <= acc_n;
			first_off_q <= first_n;
			prev_off_q  <= prev_n;
			pos_q       <= pos_n;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= adv_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv_s1 && emit) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = res_s2.kind;
	assign m_axis_tlast  = res_s2.last;
	assign m_axis_tdata  = {7'b0, res_s2.error_code, res_s2.entry_size,
		res_s2.entry_offset, res_s2.name_char};

	// A verdict always leaves the parser in its done phase.
	a_verdict_done: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && emit && res.last) |=> (phase_q == PH_DONE))
		else $error("parser not done after verdict");

	// The last flag travels only with a verdict kind.
	a_last_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |->
		(m_axis_tuser == adp_pkg::KIND_VALID || m_axis_tuser == adp_pkg::KIND_INVALID))
		else $error("last flag on a non-verdict result");

	// Error codes appear only on an invalid verdict.
	a_err_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser != adp_pkg::KIND_INVALID) |->
		(res_s2.error_code == adp_pkg::ERR_NONE))
		else $error("error code on a non-failing result");

endmodule

// File: verif/tb_archive_directory_parser_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Archive directory parser testbench
// Streams archive images byte by byte into the parser and compares every
// name byte, entry record and verdict against a cycle-free model of the
// directory rules. Directed images cover each error path. Random images,
// mostly well formed and partly damaged, follow under several file sizes
// with random back pressure on both streams.
// ---------------------------------------------------------------------------
module tb_archive_directory_parser_top;

	localparam int SETTLE_CYCLES = 8;
	localparam int IDLE_LIMIT    = 5000;
	localparam int RANDOM_BYTES  = 150;
	localparam logic [adp_pkg::OFF_W-1:0] FILE_SIZE_MAX = 31'h7FFF_FFFF;

	typedef logic [7:0] octet_t;
	typedef enum logic [1:0] {SCAN_OFFSET, SCAN_NAME, SCAN_DONE} scan_phase_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [adp_pkg::OFF_W-1:0]     cfg_wr_data;
	logic                          s_axis_tvalid;
	logic                          s_axis_tready;
	logic [adp_pkg::BYTE_W-1:0]    s_axis_tdata;
	logic                          s_axis_tuser;
	logic                          m_axis_tvalid;
	logic                          m_axis_tready;
	logic [adp_pkg::TDATA_W-1:0]   m_axis_tdata;
	logic [adp_pkg::KIND_W-1:0]    m_axis_tuser;
	logic                          m_axis_tlast;

	archive_directory_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// Clock with a 4 ns period.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Parser model state, mirrored from the block's behavior.
	logic [adp_pkg::OFF_W-1:0]  model_file_size = '0;
	scan_phase_t                scan_phase      = SCAN_OFFSET;
	logic [1:0]                 word_byte       = '0;
	logic [adp_pkg::WORD_W-1:0] offset_word     = '0;
	logic [adp_pkg::OFF_W-1:0]  dir_first_off   = '0;
	logic [adp_pkg::OFF_W-1:0]  prev_off        = '0;
	logic [adp_pkg::OFF_W-1:0]  byte_pos        = '0;

	adp_pkg::result_t pending_dir_results[$];

	int  error_count   = 0;
	int  random_bytes  = 0;
	bit  sender_gaps   = 1'b0;
	bit  receiver_gaps = 1'b0;
	int  hold_request  = 0;

	// Gap length: mostly none or short, now and then long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) begin
			return 0;
		end else if (r < 93) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	// Queue the invalid verdict and stop the parse.
	task automatic reject_directory(input logic [adp_pkg::ERR_W-1:0] code);
		adp_pkg::result_t rec;
		rec = '0;
		rec.kind = adp_pkg::KIND_INVALID;
		rec.error_code = code;
		rec.last = 1'b1;
		pending_dir_results.push_back(rec);
		scan_phase = SCAN_DONE;
	endtask

	// Advance the parser model by one accepted byte and queue its result.
	task automatic parse_dir_byte(input octet_t data, input logic first);
		logic [adp_pkg::OFF_W-1:0] pos;
		adp_pkg::result_t          rec;
		rec = '0;
		if (first) begin
			scan_phase = SCAN_OFFSET;
			word_byte = '0;
			offset_word = '0;
			dir_first_off = '0;
			prev_off = '0;
			byte_pos = '0;
		end
		if (scan_phase == SCAN_DONE) begin
			return;
		end
		pos = byte_pos;
		byte_pos = byte_pos + 31'd1;

		if (pos == '0 && model_file_size < adp_pkg::MIN_FILE) begin
			reject_directory(adp_pkg::ERR_SHORT);
		end else if (scan_phase == SCAN_OFFSET && word_byte == 2'd0 &&
				pos >= adp_pkg::WORD_BYTES && pos >= dir_first_off) begin
			// The directory area is used up without an end marker.
			reject_directory(adp_pkg::ERR_END);
		end else if (pos >= model_file_size) begin
			reject_directory(adp_pkg::ERR_PAST_END);
		end else if (scan_phase == SCAN_NAME) begin
			if (data == 8'd0) begin
				scan_phase = SCAN_OFFSET;
				word_byte = '0;
				offset_word = '0;
			end else begin
				rec.kind = adp_pkg::KIND_NAME;
				rec.name_char = (data >= 8'h41 && data <= 8'h5A) ? data + 8'h20 : data;
				pending_dir_results.push_back(rec);
			end
		end else begin
			offset_word = offset_word | (adp_pkg::WORD_W'(data) << (8 * word_byte));
			if (word_byte != 2'd3) begin
				word_byte = word_byte + 2'd1;
			end else begin
				word_byte = '0;
				if (pos < adp_pkg::WORD_BYTES) begin
					// First offset also marks where the directory ends.
					if (offset_word[31] ||
							offset_word < adp_pkg::WORD_W'(adp_pkg::MIN_FILE) ||
							offset_word > adp_pkg::WORD_W'(model_file_size)) begin
						reject_directory(adp_pkg::ERR_FIRST_OFF);
					end else begin
						dir_first_off = offset_word[adp_pkg::OFF_W-1:0];
						prev_off = offset_word[adp_pkg::OFF_W-1:0];
						scan_phase = SCAN_NAME;
					end
				end else if (offset_word == '0) begin
					if (pos + 31'd1 != dir_first_off) begin
						reject_directory(adp_pkg::ERR_END);
					end else begin
						rec.kind = adp_pkg::KIND_VALID;
						rec.entry_offset = prev_off;
						rec.entry_size = model_file_size - prev_off;
						rec.last = 1'b1;
						pending_dir_results.push_back(rec);
						scan_phase = SCAN_DONE;
					end
				end else if (offset_word[31] ||
						offset_word[adp_pkg::OFF_W-1:0] < prev_off ||
						offset_word[adp_pkg::OFF_W-1:0] > model_file_size) begin
					reject_directory(adp_pkg::ERR_ORDER);
				end else begin
					rec.kind = adp_pkg::KIND_ENTRY;
					rec.entry_offset = prev_off;
					rec.entry_size = offset_word[adp_pkg::OFF_W-1:0] - prev_off;
					pending_dir_results.push_back(rec);
					prev_off = offset_word[adp_pkg::OFF_W-1:0];
					scan_phase = SCAN_NAME;
				end
			end
		end
	endtask

	// Offer one byte and wait for its request to be taken.
	task automatic send_byte(input octet_t data, input logic first);
		int gap;
		gap = sender_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata = data;
		s_axis_tuser = first;
		s_axis_tvalid = 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		parse_dir_byte(data, first);
		@(negedge clk);
	endtask

	// Send a whole image, marking its first byte.
	task automatic send_file(ref octet_t img[$]);
		foreach (img[i]) begin
			send_byte(img[i], i == 0);
		end
	endtask

	// Wait until every queued result has come and the pipeline is empty.
	task automatic drain();
		s_axis_tvalid = 1'b0;
		while (pending_dir_results.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_file_size(input logic [adp_pkg::OFF_W-1:0] size);
		drain();
		cfg_wr_data = size;
		cfg_wr_en = 1'b1;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		model_file_size = size;
	endtask

	function automatic void push_word(ref octet_t img[$],
			input logic [adp_pkg::WORD_W-1:0] w);
		for (int i = 0; i < 4; i++) begin
			img.push_back(w[8*i +: 8]);
		end
	endfunction

	// Name bytes followed by their terminator.
	function automatic void push_name(ref octet_t img[$], input string name);
		for (int i = 0; i < name.len(); i++) begin
			img.push_back(name[i]);
		end
		img.push_back(8'd0);
	endfunction

	function automatic octet_t random_name_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4) begin
			return octet_t'($urandom_range(8'h41, 8'h5A));
		end else if (r < 6) begin
			return octet_t'($urandom_range(8'h61, 8'h7A));
		end
		return octet_t'($urandom_range(1, 255));
	endfunction

	// Well-formed directory whose offsets fit the given file size where they can.
	function automatic void build_directory(ref octet_t img[$],
			input logic [adp_pkg::OFF_W-1:0] size, input int max_name);
		int     n;
		int     name_len[4];
		longint dir_len;
		longint off;
		longint prev;
		longint span;
		n = $urandom_range(1, 4);
		dir_len = 4;
		for (int i = 0; i < n; i++) begin
			name_len[i] = $urandom_range(0, max_name);
			dir_len += 5 + name_len[i];
		end
		prev = dir_len;
		for (int i = 0; i < n; i++) begin
			if (i == 0) begin
				off = dir_len;
			end else begin
				span = (longint'(size) > prev) ? longint'(size) - prev : 0;
				off = ($urandom_range(0, 4) == 0) ? prev :
					prev + (longint'($urandom) % (span + 1));
			end
			push_word(img, adp_pkg::WORD_W'(off));
			for (int j = 0; j < name_len[i]; j++) begin
				img.push_back(random_name_char());
			end
			img.push_back(8'd0);
			prev = off;
		end
		push_word(img, '0);
	endfunction

	// A stream with no restart after reset starts at position zero.
	task automatic test_no_first_flag();
		send_byte(8'hA5, 1'b0);
		send_byte(8'h5A, 1'b0);
	endtask

	task automatic test_short_file();
		octet_t img[$];
		set_file_size(31'd4);
		push_word(img, 32'd9);
		send_file(img);
		set_file_size(31'd0);
		img = '{8'hFF};
		send_file(img);
	endtask

	// Negative, too small and too large first offsets.
	task automatic test_first_offset();
		octet_t img[$];
		set_file_size(31'd40);
		push_word(img, 32'h8000_0005);
		send_file(img);
		img.delete();
		push_word(img, 32'd4);
		send_file(img);
		img.delete();
		push_word(img, 32'd41);
		send_file(img);
	endtask

	// Uppercase and boundary name bytes, an empty name and bytes after the verdict.
	task automatic test_valid_directory();
		octet_t img[$];
		set_file_size(31'd40);
		push_word(img, 32'd19);
		push_name(img, "AZ@[");
		img.insert(img.size() - 1, 8'hC1);
		push_word(img, 32'd30);
		push_name(img, "");
		push_word(img, 32'd0);
		img.push_back(8'h41);
		img.push_back(8'h00);
		send_file(img);
	endtask

	// Later offsets that decrease, run past the file or are negative.
	task automatic test_order_errors();
		octet_t img[$];
		logic [adp_pkg::WORD_W-1:0] bad_offsets[3];
		bad_offsets = '{32'd10, 32'd41, 32'h8000_0014};
		foreach (bad_offsets[i]) begin
			img.delete();
			push_word(img, 32'd20);
			push_name(img, "");
			push_word(img, bad_offsets[i]);
			send_file(img);
		end
	endtask

	// End marker too early, and a directory area used up without one.
	task automatic test_end_misplaced();
		octet_t img[$];
		push_word(img, 32'd20);
		push_name(img, "");
		push_word(img, 32'd0);
		send_file(img);
		img.delete();
		push_word(img, 32'd9);
		push_name(img, "");
		push_word(img, 32'd12);
		push_name(img, "");
		img.push_back(8'h01);
		send_file(img);
	endtask

	// A name that runs into the end of the file.
	task automatic test_past_end();
		octet_t img[$];
		set_file_size(31'd10);
		push_word(img, 32'd10);
		push_name(img, "abcdefg");
		send_file(img);
	endtask

	task automatic test_max_file_size();
		octet_t img[$];
		set_file_size(FILE_SIZE_MAX);
		push_word(img, 32'd14);
		push_name(img, "");
		push_word(img, 32'h7FFF_FFFF);
		push_name(img, "");
		push_word(img, 32'd0);
		send_file(img);
	endtask

	// The receiver stops for a long stretch while long names keep coming.
	task automatic test_backpressure();
		octet_t img[$];
		sender_gaps = 1'b0;
		hold_request = 300;
		build_directory(img, model_file_size, 16);
		send_file(img);
		img.delete();
		build_directory(img, model_file_size, 16);
		send_file(img);
	endtask

	// The sender stops until every result of the first image is in.
	task automatic test_sender_pause();
		octet_t img[$];
		sender_gaps = 1'b1;
		build_directory(img, model_file_size, 5);
		send_file(img);
		drain();
		img.delete();
		build_directory(img, model_file_size, 5);
		send_file(img);
	endtask

	// Random images under a range of file sizes, mostly well formed.
	task automatic test_random_directories();
		octet_t img[$];
		int     r;
		int     cut;
		while (random_bytes < RANDOM_BYTES) begin
			case ($urandom_range(0, 5))
				0: set_file_size(31'd24);
				1: set_file_size(31'd48);
				2: set_file_size(31'($urandom_range(0, 300)));
				3: set_file_size(FILE_SIZE_MAX);
				default: set_file_size(31'($urandom) | 31'h100);
			endcase
			for (int d = 0; d < 6; d++) begin
				sender_gaps = $urandom_range(0, 3) != 0;
				receiver_gaps = $urandom_range(0, 3) != 0;
				img.delete();
				r = $urandom_range(0, 99);
				if (r < 15) begin
					// Noise, now and then with a restart inside.
					repeat ($urandom_range(1, 12)) img.push_back(octet_t'($urandom));
					foreach (img[i]) begin
						send_byte(img[i], i == 0 || $urandom_range(0, 9) == 0);
					end
				end else begin
					build_directory(img, model_file_size, 5);
					if (r < 35) begin
						cut = $urandom_range(0, img.size() - 1);
						case ($urandom_range(0, 2))
							0: img[cut] = octet_t'($urandom);
							1: img = img[0:cut];
							default: repeat ($urandom_range(1, 6)) img.push_back(octet_t'($urandom));
						endcase
					end
					send_file(img);
				end
				random_bytes += img.size();
			end
		end
	endtask

	// Receiver: random stalls, plus one long hold when asked for.
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else begin
				m_axis_tready = 1'b1;
				stall_left = receiver_gaps ? pick_gap() : 0;
			end
		end
	end

	task automatic check_field(input string field, input logic [adp_pkg::WORD_W-1:0] want,
			input logic [adp_pkg::WORD_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
			error_count++;
		end
	endtask

	// Compare each result taken from the master stream with the oldest one queued.
	always @(posedge clk) begin : check_results
		adp_pkg::result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_dir_results.size() == 0) begin
				$error("unexpected result: kind %0d, tdata 0x%0h", m_axis_tuser, m_axis_tdata);
				error_count++;
			end else begin
				want = pending_dir_results.pop_front();
				check_field("result_kind", adp_pkg::WORD_W'(want.kind),
					adp_pkg::WORD_W'(m_axis_tuser));
				check_field("name_char", adp_pkg::WORD_W'(want.name_char),
					adp_pkg::WORD_W'(m_axis_tdata[7:0]));
				check_field("entry_offset", adp_pkg::WORD_W'(want.entry_offset),
					adp_pkg::WORD_W'(m_axis_tdata[38:8]));
				check_field("entry_size", adp_pkg::WORD_W'(want.entry_size),
					adp_pkg::WORD_W'(m_axis_tdata[69:39]));
				check_field("error_code", adp_pkg::WORD_W'(want.error_code),
					adp_pkg::WORD_W'(m_axis_tdata[72:70]));
				check_field("last", adp_pkg::WORD_W'(want.last),
					adp_pkg::WORD_W'(m_axis_tlast));
			end
		end
	end

	// Watchdog: ends the run when no request moves for too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$error("timeout: no request accepted for %0d cycles", IDLE_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_no_first_flag();
		test_short_file();
		test_first_offset();
		test_valid_directory();
		test_order_errors();
		test_end_misplaced();
		test_past_end();
		test_max_file_size();
		test_backpressure();
		test_sender_pause();
		test_random_directories();

		drain();
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/adp_pkg.sv
rtl/core/archive_directory_parser_top.sv
verif/tb_archive_directory_parser_top.sv
